### hdl/ddet_pkg.sv
package ddet_pkg;

  // Operation carried by the mode field of an input request
  typedef enum logic [1:0] {
    MODE_LOAD_ALLOC = 2'd0,
    MODE_LOAD_REQ   = 2'd1,
    MODE_LOAD_AVAIL = 2'd2,
    MODE_RUN        = 2'd3
  } mode_e;

  // Configuration register indexes
  localparam logic REG_PROCS = 1'b0;
  localparam logic REG_RES   = 1'b1;

  // Register widths and reset values
  localparam int unsigned PROCS_W = 5;
  localparam int unsigned RES_W   = 4;
  localparam int unsigned CFG_W   = 5;
  localparam logic [PROCS_W-1:0] PROCS_RST = 5'd16;
  localparam logic [RES_W-1:0]   RES_RST   = 4'd8;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,  // takes loads and run requests
    S_HOLD  = 7'b0000010,  // marks processes that hold nothing
    S_COPY  = 7'b0000100,  // work <= available
    S_PICK  = 7'b0001000,  // choose next unfinished process
    S_CHECK = 7'b0010000,  // compare request row against work
    S_ADD   = 7'b0100000,  // release allocation row into work
    S_EMIT  = 7'b1000000   // stream verdicts
  } state_e;

endpackage

### hdl/deadlock_detector.sv
// Deadlock detector.
// Input channel (in_valid_i / in_stall_o) carries load and run requests.
// Loads write one allocation, request or available count and produce no
// result. A run request scans the stores and then returns one result per
// process in use on the output channel (out_valid_o / out_stall_i),
// process 0 first, last_o on the final one.
// A run first reads every allocation entry in use and the available
// counts, then sweeps the processes, checking each unfinished one and
// releasing its allocation when its request fits, for at most P+1 sweeps
// with P processes in use, then emits the results. The matrix memories
// each have a single read port and deliver one count per cycle.
// Input is stalled from the start of a run until its final result is in
// the output register; that result may wait there while loads go on.
// A stalled result holds; emission simply pauses until it is taken.
// Reset clears the sequencer, the work counts and the finished marks and
// sets procs_q to 16 and res_q to 8; the count stores stay undefined
// until loaded, and every entry a run reads must be loaded first.
module deadlock_detector #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned MAX_RESOURCES = 8,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic                   cfg_addr_i,
  input  logic [ddet_pkg::CFG_W-1:0] cfg_wdata_i,
  // input requests
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             mode_i,
  input  logic [3:0]             process_index_i,
  input  logic [2:0]             resource_index_i,
  input  logic [15:0]            count_value_i,
  // results
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [3:0]             proc_id_o,
  output logic                   deadlocked_o,
  output logic                   last_o
);

  import ddet_pkg::*;

  localparam int unsigned PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned RB = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int unsigned IW = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned JW = $clog2(MAX_RESOURCES + 1);
  localparam int unsigned AW = PW + RB;
  localparam int unsigned MDEPTH = 2 ** AW;

  // registers
  state_e                state_q, state_d;
  logic [PROCS_W-1:0]    procs_q;
  logic [RES_W-1:0]      res_q;
  logic [IW-1:0]         np_q, np_d;
  logic [JW-1:0]         nr_q, nr_d;
  logic [IW-1:0]         i_q, i_d;
  logic [IW-1:0]         e_q, e_d;
  logic [JW-1:0]         j_q, j_d;
  logic                  iss_q, iss_d;
  logic                  rd_vld_q;
  logic [JW-1:0]         rd_j_q;
  logic                  rd_last_q;
  logic                  acc_q, acc_d;
  logic                  chg_q, chg_d;
  logic [MAX_PROCESSES-1:0] fin_q, fin_d;
  logic [COUNT_BITS-1:0] work_q [MAX_RESOURCES];
  logic [COUNT_BITS-1:0] work_d [MAX_RESOURCES];
  logic                  out_vld_q, out_vld_d;
  logic [3:0]            out_id_q, out_id_d;
  logic                  out_dead_q, out_dead_d;
  logic                  out_last_q, out_last_d;

  // datapath signals
  logic                  in_acc;
  mode_e                 mode;
  logic                  idx_ok_p, idx_ok_r;
  logic [COUNT_BITS-1:0] cnt_val;
  logic [AW-1:0]         load_addr, run_addr;
  logic [RB-1:0]         avail_addr;
  logic                  alloc_we, req_we, avail_we;
  logic [COUNT_BITS-1:0] alloc_rd, req_rd, avail_rd;
  logic [COUNT_BITS-1:0] work_rd;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] sat_sum;
  logic                  nz, fail;
  logic [IW-1:0]         np_clamp;
  logic [JW-1:0]         nr_clamp;
  logic [JW-1:0]         nr_m1;
  logic                  slot_free;

  // input decode
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mode       = mode_e'(mode_i);
  assign idx_ok_p   = 32'(process_index_i) < MAX_PROCESSES;
  assign idx_ok_r   = 32'(resource_index_i) < MAX_RESOURCES;
  assign cnt_val    = COUNT_BITS'(count_value_i);
  assign load_addr  = {PW'(process_index_i), RB'(resource_index_i)};

  always_comb begin
    alloc_we = 1'b0;
    req_we   = 1'b0;
    avail_we = 1'b0;
    case (mode)
      MODE_LOAD_ALLOC: alloc_we = in_acc && idx_ok_p && idx_ok_r;
      MODE_LOAD_REQ:   req_we   = in_acc && idx_ok_p && idx_ok_r;
      MODE_LOAD_AVAIL: avail_we = in_acc && idx_ok_r;
      MODE_RUN:        ;
      default:         ;
    endcase
  end

  // read addresses follow the issue counter
  assign run_addr   = {i_q[PW-1:0], j_q[RB-1:0]};
  assign avail_addr = j_q[RB-1:0];

  ddet_ram #(.WIDTH(COUNT_BITS), .DEPTH(MDEPTH), .AW(AW)) u_alloc (
    .clk_i   (clk_i),
    .we_i    (alloc_we),
    .waddr_i (load_addr),
    .wdata_i (cnt_val),
    .raddr_i (run_addr),
    .rdata_o (alloc_rd)
  );

  ddet_ram #(.WIDTH(COUNT_BITS), .DEPTH(MDEPTH), .AW(AW)) u_req (
    .clk_i   (clk_i),
    .we_i    (req_we),
    .waddr_i (load_addr),
    .wdata_i (cnt_val),
    .raddr_i (run_addr),
    .rdata_o (req_rd)
  );

  ddet_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_RESOURCES), .AW(RB)) u_avail (
    .clk_i   (clk_i),
    .we_i    (avail_we),
    .waddr_i (RB'(resource_index_i)),
    .wdata_i (cnt_val),
    .raddr_i (avail_addr),
    .rdata_o (avail_rd)
  );

  // register clamping: zero means one, above the maximum means the maximum
  always_comb begin
    if (procs_q == '0) begin
      np_clamp = IW'(1);
    end else if (32'(procs_q) > MAX_PROCESSES) begin
      np_clamp = IW'(MAX_PROCESSES);
    end else begin
      np_clamp = IW'(procs_q);
    end
    if (res_q == '0) begin
      nr_clamp = JW'(1);
    end else if (32'(res_q) > MAX_RESOURCES) begin
      nr_clamp = JW'(MAX_RESOURCES);
    end else begin
      nr_clamp = JW'(res_q);
    end
  end

  // returned data against work
  assign work_rd = work_q[rd_j_q[RB-1:0]];
  assign sum     = {1'b0, work_rd} + {1'b0, alloc_rd};
  assign sat_sum = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  assign nz      = (alloc_rd != '0);
  assign fail    = acc_q || (req_rd > work_rd);
  assign nr_m1   = nr_q - JW'(1);
  assign slot_free = !out_vld_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d    = state_q;
    np_d       = np_q;
    nr_d       = nr_q;
    i_d        = i_q;
    e_d        = e_q;
    acc_d      = acc_q;
    chg_d      = chg_q;
    fin_d      = fin_q;
    work_d     = work_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_id_d   = out_id_q;
    out_dead_d = out_dead_q;
    out_last_d = out_last_q;

    // issue one read per cycle while a row scan is open
    j_d   = j_q;
    iss_d = iss_q;
    if (iss_q) begin
      j_d = j_q + JW'(1);
      if (j_q == nr_m1) begin
        iss_d = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && mode == MODE_RUN) begin
          np_d    = np_clamp;
          nr_d    = nr_clamp;
          i_d     = '0;
          acc_d   = 1'b0;
          j_d     = '0;
          iss_d   = 1'b1;
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (rd_vld_q) begin
          acc_d = acc_q || nz;
          if (rd_last_q) begin
            fin_d[i_q[PW-1:0]] = !(acc_q || nz);
            acc_d = 1'b0;
            j_d   = '0;
            iss_d = 1'b1;
            if (i_q == np_q - IW'(1)) begin
              i_d     = '0;
              state_d = S_COPY;
            end else begin
              i_d = i_q + IW'(1);
            end
          end
        end
      end
      S_COPY: begin
        if (rd_vld_q) begin
          work_d[rd_j_q[RB-1:0]] = avail_rd;
          if (rd_last_q) begin
            i_d     = '0;
            chg_d   = 1'b0;
            state_d = S_PICK;
          end
        end
      end
      S_PICK: begin
        if (i_q == np_q) begin
          i_d = '0;
          if (chg_q) begin
            chg_d = 1'b0;
          end else begin
            e_d     = '0;
            state_d = S_EMIT;
          end
        end else if (fin_q[i_q[PW-1:0]]) begin
          i_d = i_q + IW'(1);
        end else begin
          acc_d   = 1'b0;
          j_d     = '0;
          iss_d   = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (rd_vld_q) begin
          acc_d = fail;
          if (rd_last_q) begin
            acc_d = 1'b0;
            if (!fail) begin
              j_d     = '0;
              iss_d   = 1'b1;
              state_d = S_ADD;
            end else begin
              i_d     = i_q + IW'(1);
              state_d = S_PICK;
            end
          end
        end
      end
      S_ADD: begin
        if (rd_vld_q) begin
          work_d[rd_j_q[RB-1:0]] = sat_sum;
          if (rd_last_q) begin
            fin_d[i_q[PW-1:0]] = 1'b1;
            chg_d   = 1'b1;
            i_d     = i_q + IW'(1);
            state_d = S_PICK;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_id_d   = 4'(e_q);
          out_dead_d = !fin_q[e_q[PW-1:0]];
          out_last_d = (e_q == np_q - IW'(1));
          e_d        = e_q + IW'(1);
          if (e_q == np_q - IW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      procs_q   <= PROCS_RST;
      res_q     <= RES_RST;
      np_q      <= '0;
      nr_q      <= '0;
      i_q       <= '0;
      e_q       <= '0;
      j_q       <= '0;
      iss_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_j_q    <= '0;
      rd_last_q <= 1'b0;
      acc_q     <= 1'b0;
      chg_q     <= 1'b0;
      fin_q     <= '0;
      out_vld_q <= 1'b0;
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        work_q[k] <= '0;
      end
    end else begin
      state_q   <= state_d;
      np_q      <= np_d;
      nr_q      <= nr_d;
      i_q       <= i_d;
      e_q       <= e_d;
      j_q       <= j_d;
      iss_q     <= iss_d;
      rd_vld_q  <= iss_q;
      rd_j_q    <= j_q;
      rd_last_q <= iss_q && (j_q == nr_m1);
      acc_q     <= acc_d;
      chg_q     <= chg_d;
      fin_q     <= fin_d;
      out_vld_q <= out_vld_d;
      work_q    <= work_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_PROCS: procs_q <= cfg_wdata_i[PROCS_W-1:0];
          REG_RES:   res_q   <= cfg_wdata_i[RES_W-1:0];
          default:   ;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_id_q   <= out_id_d;
    out_dead_q <= out_dead_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_vld_q;
  assign proc_id_o    = out_id_q;
  assign deadlocked_o = out_dead_q;
  assign last_o       = out_last_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !iss_q && !rd_vld_q)
    else $error("memory reads in flight while idle");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK || state_q == S_ADD) |-> i_q < np_q)
    else $error("row scan beyond processes in use");

  a_read_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(iss_q))
    else $error("read data without an issued read");
`endif

endmodule

### hdl/ddet_ram.sv
module ddet_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### dv/deadlock_detector_tb.sv
`timescale 1ns / 100ps

module deadlock_detector_tb;
  import ddet_pkg::*;

  localparam int unsigned NPROC      = 16;
  localparam int unsigned NRES       = 8;
  localparam int unsigned SETTLE     = 8;      // cycles after the last verdict
  localparam int unsigned HOLD_OFF   = 500;    // long receiver hold-off
  localparam int unsigned QUIET_MAX  = 20000;  // cycles without any acceptance

  // one verdict of a detection run
  typedef struct packed {
    logic [3:0] proc_id;
    logic       deadlocked;
    logic       last;
  } verdict_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_addr_i;
  logic [CFG_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         mode_i;
  logic [3:0]         process_index_i;
  logic [2:0]         resource_index_i;
  logic [15:0]        count_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [3:0]         proc_id_o;
  logic               deadlocked_o;
  logic               last_o;

  // predictor state
  logic [15:0]        alloc_m [NPROC][NRES];
  logic [15:0]        req_m   [NPROC][NRES];
  logic [15:0]        avail_v [NRES];
  logic [4:0]         procs_cfg;
  logic [3:0]         res_cfg;
  verdict_t           verdict_q [$];

  int unsigned        mismatches;
  int unsigned        quiet_cycles;
  bit                 no_gaps;
  bit                 hold_out;

  deadlock_detector DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .process_index_i  (process_index_i),
    .resource_index_i (resource_index_i),
    .count_value_i    (count_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .proc_id_o        (proc_id_o),
    .deadlocked_o     (deadlocked_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Detection: mark idle holders, sweep until nothing changes, queue verdicts
  function automatic void predict_detection();
    int unsigned np;
    int unsigned nr;
    logic [15:0] work [NRES];
    bit          done [NPROC];
    bit          changed;
    bit          fits;
    logic [16:0] sum;
    verdict_t    vd;
    np = (procs_cfg == 0) ? 1 : (procs_cfg > NPROC) ? NPROC : procs_cfg;
    nr = (res_cfg == 0) ? 1 : (res_cfg > NRES) ? NRES : res_cfg;
    for (int i = 0; i < np; i++) begin
      done[i] = 1'b1;
      for (int j = 0; j < nr; j++)
        if (alloc_m[i][j] != 0) done[i] = 1'b0;
    end
    for (int j = 0; j < nr; j++) work[j] = avail_v[j];
    do begin
      changed = 1'b0;
      for (int i = 0; i < np; i++) begin
        if (!done[i]) begin
          fits = 1'b1;
          for (int j = 0; j < nr; j++)
            if (req_m[i][j] > work[j]) fits = 1'b0;
          if (fits) begin
            // release allocation, saturating
            for (int j = 0; j < nr; j++) begin
              sum = {1'b0, work[j]} + {1'b0, alloc_m[i][j]};
              work[j] = sum[16] ? 16'hFFFF : sum[15:0];
            end
            done[i] = 1'b1;
            changed = 1'b1;
          end
        end
      end
    end while (changed);
    for (int i = 0; i < np; i++) begin
      vd.proc_id    = i[3:0];
      vd.deadlocked = !done[i];
      vd.last       = (i + 1 == np);
      verdict_q.push_back(vd);
    end
  endfunction

  function automatic void apply_request(mode_e m, logic [3:0] p, logic [2:0] r,
                                        logic [15:0] v);
    case (m)
      MODE_LOAD_ALLOC: alloc_m[p][r] = v;
      MODE_LOAD_REQ:   req_m[p][r] = v;
      MODE_LOAD_AVAIL: avail_v[r] = v;
      default:         predict_detection();
    endcase
  endfunction

  // Mostly small counts so runs mix deadlocked and free processes
  function automatic logic [15:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return 16'($urandom_range(3));
    if (roll < 85) return 16'($urandom_range(65535));
    if (roll < 93) return 16'hFFFF;
    return 16'h0000;
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(input mode_e m, input logic [3:0] p, input logic [2:0] r,
                              input logic [15:0] v);
    logic stalled;
    while (!no_gaps && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= m;
    process_index_i  <= p;
    resource_index_i <= r;
    count_value_i    <= v;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    apply_request(m, p, r, v);
  endtask

  task automatic send_random_load();
    mode_e m;
    m = mode_e'($urandom_range(MODE_LOAD_AVAIL));
    send_request(m, 4'($urandom_range(15)), 3'($urandom_range(7)), pick_count());
  endtask

  // Stop offering and wait for every pending verdict
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [4:0] procs, input logic [4:0] res);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_PROCS;
    cfg_wdata_i <= procs;
    @(posedge clk_i);
    procs_cfg = procs;
    cfg_addr_i  <= REG_RES;
    cfg_wdata_i <= res;
    @(posedge clk_i);
    res_cfg = res[3:0];
    cfg_we_i <= 1'b0;
  endtask

  // Two processes, each waiting on the other's single unit
  task automatic test_basic_deadlock();
    set_config(5'd2, 5'd1);
    send_request(MODE_LOAD_ALLOC, 4'd0, 3'd0, 16'd1);
    send_request(MODE_LOAD_ALLOC, 4'd1, 3'd0, 16'd1);
    send_request(MODE_LOAD_REQ,   4'd0, 3'd0, 16'd1);
    send_request(MODE_LOAD_REQ,   4'd1, 3'd0, 16'd1);
    // process index is don't-care on available loads
    send_request(MODE_LOAD_AVAIL, 4'd15, 3'd0, 16'd0);
    send_request(MODE_RUN,        4'd0, 3'd0, 16'd0);
    send_request(MODE_LOAD_AVAIL, 4'd9, 3'd0, 16'd1);
    send_request(MODE_RUN,        4'd15, 3'd7, 16'hFFFF);
  endtask

  // Work must clamp at all ones, not wrap, or process 1 stays blocked
  task automatic test_saturation();
    send_request(MODE_LOAD_ALLOC, 4'd0, 3'd0, 16'hFFFF);
    send_request(MODE_LOAD_AVAIL, 4'd0, 3'd0, 16'hFFFF);
    send_request(MODE_LOAD_REQ,   4'd0, 3'd0, 16'd0);
    send_request(MODE_LOAD_REQ,   4'd1, 3'd0, 16'hFFFF);
    send_request(MODE_LOAD_ALLOC, 4'd1, 3'd0, 16'd1);
    send_request(MODE_RUN,        4'd0, 3'd0, 16'd0);
  endtask

  // A process holding nothing is finished even with a huge request
  task automatic test_idle_holder();
    send_request(MODE_LOAD_ALLOC, 4'd1, 3'd0, 16'd0);
    send_request(MODE_LOAD_REQ,   4'd1, 3'd0, 16'hFFFF);
    send_request(MODE_LOAD_AVAIL, 4'd0, 3'd0, 16'd0);
    send_request(MODE_LOAD_REQ,   4'd0, 3'd0, 16'd1);
    send_request(MODE_RUN,        4'd0, 3'd0, 16'd0);
  endtask

  // Zero in both registers acts as one
  task automatic test_register_clamp();
    set_config(5'd0, 5'd0);
    send_request(MODE_RUN, 4'd0, 3'd0, 16'd0);
  endtask

  // Fill every store entry, then random load/run sequences per setting
  task automatic test_random_mix();
    logic [4:0] procs_set [6] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd12};
    logic [4:0] res_set   [6] = '{5'd8, 5'd1, 5'd31, 5'd16, 5'd3, 5'd6};
    for (int p = 0; p < NPROC; p++)
      for (int r = 0; r < NRES; r++) begin
        send_request(MODE_LOAD_ALLOC, p[3:0], r[2:0], pick_count());
        send_request(MODE_LOAD_REQ, p[3:0], r[2:0], pick_count());
      end
    for (int r = 0; r < NRES; r++)
      send_request(MODE_LOAD_AVAIL, 4'($urandom_range(15)), r[2:0], pick_count());
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) set_config(procs_set[ph], res_set[ph]);
      else set_config(5'($urandom_range(31)), 5'($urandom_range(31)));
      repeat (4) begin
        repeat ($urandom_range(5)) send_random_load();
        // occasionally loads only, no run
        if ($urandom_range(9) != 0)
          send_request(MODE_RUN, 4'($urandom_range(15)), 3'($urandom_range(7)),
                       16'($urandom_range(65535)));
      end
    end
  endtask

  // Receiver holds off while runs and loads keep coming
  task automatic test_back_pressure();
    set_config(5'd16, 5'd8);
    hold_out = 1'b1;
    send_request(MODE_RUN, 4'd0, 3'd0, 16'd0);
    repeat (5) send_random_load();
    send_request(MODE_RUN, 4'd0, 3'd0, 16'd0);
    repeat (4) send_random_load();
    send_request(MODE_RUN, 4'd0, 3'd0, 16'd0);
  endtask

  // Back to back on both sides
  task automatic test_burst();
    set_config(5'd7, 5'd4);
    no_gaps = 1'b1;
    repeat (4) begin
      repeat (4) send_random_load();
      send_request(MODE_RUN, 4'd0, 3'd0, 16'd0);
    end
    wait_idle();
    no_gaps = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk_i);
        hold_out = 1'b0;
      end
      out_stall_i <= !no_gaps && ($urandom_range(99) < 17);
    end
  end

  // Verdict checker, sampled mid-cycle
  initial begin
    verdict_t exp_v;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected verdict for process %0d", proc_id_o);
          mismatches++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (proc_id_o !== exp_v.proc_id) begin
            $error("proc_id: expected %0d, got %0d", exp_v.proc_id, proc_id_o);
            mismatches++;
          end
          if (deadlocked_o !== exp_v.deadlocked) begin
            $error("deadlocked: expected %0d, got %0d", exp_v.deadlocked, deadlocked_o);
            mismatches++;
          end
          if (last_o !== exp_v.last) begin
            $error("last: expected %0d, got %0d", exp_v.last, last_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  initial begin
    quiet_cycles = 0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
          (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else if (++quiet_cycles >= QUIET_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0;
    no_gaps    = 1'b0;
    hold_out   = 1'b0;
    procs_cfg  = PROCS_RST;
    res_cfg    = RES_RST;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_addr_i       <= REG_PROCS;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    mode_i           <= MODE_LOAD_ALLOC;
    process_index_i  <= '0;
    resource_index_i <= '0;
    count_value_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_deadlock();
    test_saturation();
    test_idle_holder();
    test_register_clamp();
    test_random_mix();
    test_back_pressure();
    test_burst();

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ddet_pkg.sv
hdl/ddet_ram.sv
hdl/deadlock_detector.sv
dv/deadlock_detector_tb.sv
